@@ sv/tas_pkg.sv @@
`default_nettype none
package tas_pkg;

	// fixed field widths
	localparam int CMD_W      = 3;
	localparam int TYPE_W     = 6;
	localparam int ADDR_W     = 9;
	localparam int BYTE_W     = 8;
	localparam int POS_W      = 9;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HALT       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE_BASE = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  REG_LOOP_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_HALT_CODE = 2'd1;
	localparam logic [CFG_DATA_W-1:0] LOOP_CODE_RST = 8'hFF;
	localparam logic [CFG_DATA_W-1:0] HALT_CODE_RST = 8'h00;

	// address unit operations
	typedef enum logic [1:0] {
		AOP_REDUCE,
		AOP_INC1,
		AOP_INC2
	} addr_op_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TYPE_W-1:0] entry_type;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] byte_value;
		logic              base_enable;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  frame_character;
		logic [POS_W-1:0]   frame_position;
		logic [COUNT_W-1:0] hold_count;
	} out_item_t;

endpackage
`default_nettype wire

@@ sv/tas_addr_unit.sv @@
`default_nettype none
// shared address adder: add 0/1/2, then fold once modulo the table size
module tas_addr_unit #(
	parameter int TABLE_BYTES = 512,
	localparam int AW = $clog2(TABLE_BYTES),
	localparam int OW = ((AW > tas_pkg::ADDR_W) ? AW : tas_pkg::ADDR_W) + 1
) (
	input  wire tas_pkg::addr_op_t op,
	input  wire logic [OW-1:0]     operand,
	output logic [OW-1:0]          res,
	output logic                   over
);
	import tas_pkg::*;

	logic [OW-1:0] inc;
	logic [OW-1:0] sum;

	always_comb begin
		case (op)
			AOP_REDUCE: inc = '0;
			AOP_INC1:   inc = OW'(1);
			AOP_INC2:   inc = OW'(2);
			default:    inc = '0;
		endcase
	end

	assign sum  = operand + inc;
	assign over = (sum >= OW'(TABLE_BYTES));
	assign res  = over ? (sum - OW'(TABLE_BYTES)) : sum;

endmodule
`default_nettype wire

@@ sv/tile_animation_sequencer_top.sv @@
`default_nettype none
// Channel   | Signals                                 | Handshake
// ----------+-----------------------------------------+---------------------------------
// command   | start, busy, item                       | beat when start && !busy
// result    | done, result                            | one-cycle strobe, no backpressure
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | beat when cfg_valid && cfg_ready
//
// Every command beat yields exactly one result beat; fields are zero except on a read.
// Busy: first the address is folded below TABLE_BYTES (one subtract per cycle, none needed
// when TABLE_BYTES >= 512); then a table write or an ignored command ends, halt and base
// write go through S_TREAD and S_TEVAL, read adds S_RDOUT, start adds S_CHK and S_CNT.
// Tick and restart walk all NUM_TYPES types through the one address unit and the single
// read port of each memory: S_SCAN per disabled type, S_SCAN and S_TEVAL per enabled
// type that only counts down, plus S_CHK and S_CNT per type that steps to a new frame.
// The result strobe rises on the edge that drops busy; the next command can be taken then.
// Reset clears control, registers and per-type valid flags; there is no clearing pass.
// The frame table is undefined until written. cfg_ready is always high.
module tile_animation_sequencer_top #(
	parameter int NUM_TYPES   = 64,
	parameter int TABLE_BYTES = 512
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire tas_pkg::in_item_t              item,
	output logic                                done,
	output tas_pkg::out_item_t                  result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tas_pkg::*;

	localparam int AW  = $clog2(TABLE_BYTES);
	localparam int TW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int OW  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
	localparam int TXW = ((TW > TYPE_W) ? TW : TYPE_W) + 1;
	localparam int PW  = (AW > POS_W) ? AW : POS_W;

	typedef struct packed {
		logic [AW-1:0]      base;
		logic [AW-1:0]      pos;
		logic [COUNT_W-1:0] cnt;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,   // fold address below TABLE_BYTES
		S_TREAD,  // fetch record of one addressed type
		S_SCAN,   // walk types for tick / restart
		S_TEVAL,  // record in hand, act on command
		S_CHK,    // frame byte in hand, loop-code check
		S_CNT,    // hold byte in hand, write back record
		S_RDOUT   // read result
	} state_t;

	state_t state_q;

	// latched command
	logic [CMD_W-1:0]  cmd_q;
	logic [TW-1:0]     idx_q;
	logic [OW-1:0]     a_q;
	logic [BYTE_W-1:0] val_q;
	logic              en_q;
	logic              tok_q;

	logic [BYTE_W-1:0]  loop_q;
	logic [COUNT_W-1:0] halt_q;

	logic [NUM_TYPES-1:0] bvalid_q;
	logic [NUM_TYPES-1:0] wr_q;

	rec_t              tmem [NUM_TYPES];
	rec_t              tm_rdata_q;
	logic [BYTE_W-1:0] ftab [TABLE_BYTES];
	logic [BYTE_W-1:0] ft_rdata_q;

	logic       done_q;
	out_item_t  res_q;

	// combinational
	rec_t               rec;
	logic [COUNT_W-1:0] cnt_dec;
	logic [AW-1:0]      chk_a;
	logic [TXW-1:0]     type_x;
	logic               last_type;
	addr_op_t           u_op;
	logic [OW-1:0]      u_operand;
	logic [OW-1:0]      u_res;
	logic               u_over;
	logic               ft_re;
	logic               ft_we;
	logic [AW-1:0]      ft_raddr;
	logic               tm_re;
	logic               tm_we;
	rec_t               tm_wdata;
	logic [PW-1:0]      pos_x;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	// never-written records read as reset zeros
	assign rec       = wr_q[idx_q] ? tm_rdata_q : '0;
	assign cnt_dec   = rec.cnt - COUNT_W'(1);
	assign chk_a     = (ft_rdata_q == loop_q) ? rec.base : a_q[AW-1:0];
	assign type_x    = TXW'(item.entry_type);
	assign last_type = (idx_q == TW'(NUM_TYPES - 1));
	assign pos_x     = PW'(rec.pos);

	tas_addr_unit #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_addr (
		.op     (u_op),
		.operand(u_operand),
		.res    (u_res),
		.over   (u_over)
	);

	always_comb begin
		case (state_q)
			S_TEVAL: begin
				u_op      = AOP_INC2;
				u_operand = OW'(rec.pos);
			end
			S_CHK: begin
				u_op      = AOP_INC1;
				u_operand = OW'(chk_a);
			end
			default: begin
				u_op      = AOP_REDUCE;
				u_operand = a_q;
			end
		endcase
	end

	// frame table port control
	always_comb begin
		ft_re    = (state_q == S_TEVAL) || (state_q == S_CHK);
		ft_we    = (state_q == S_WRAP) && !u_over && (cmd_q == CMD_WRITE_BYTE);
		ft_raddr = a_q[AW-1:0];
		if (state_q == S_CHK) begin
			ft_raddr = u_res[AW-1:0];
		end else begin
			case (cmd_q)
				CMD_TICK:    ft_raddr = u_res[AW-1:0];
				CMD_RESTART: ft_raddr = rec.base;
				CMD_READ:    ft_raddr = rec.pos;
				default:     ft_raddr = a_q[AW-1:0];
			endcase
		end
	end

	// type record port control
	always_comb begin
		tm_re    = (state_q == S_TREAD) || ((state_q == S_SCAN) && bvalid_q[idx_q]);
		tm_we    = 1'b0;
		tm_wdata = rec;
		case (state_q)
			S_TEVAL: begin
				case (cmd_q)
					CMD_TICK: begin
						tm_we        = (rec.cnt != halt_q) && (cnt_dec != '0);
						tm_wdata.cnt = cnt_dec;
					end
					CMD_HALT: begin
						tm_we        = 1'b1;
						tm_wdata.cnt = halt_q;
					end
					CMD_WRITE_BASE: begin
						tm_we         = 1'b1;
						tm_wdata.base = a_q[AW-1:0];
					end
					default: tm_we = 1'b0;
				endcase
			end
			S_CNT: begin
				tm_we        = 1'b1;
				tm_wdata.pos = a_q[AW-1:0];
				tm_wdata.cnt = ft_rdata_q;
			end
			default: tm_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ft_we) begin
			ftab[a_q[AW-1:0]] <= val_q;
		end
		if (ft_re) begin
			ft_rdata_q <= ftab[ft_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tm_we) begin
			tmem[idx_q] <= tm_wdata;
		end
		if (tm_re) begin
			tm_rdata_q <= tmem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= LOOP_CODE_RST;
			halt_q <= HALT_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_LOOP_CODE) begin
				loop_q <= cfg_data;
			end
			if (cfg_index == REG_HALT_CODE) begin
				halt_q <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			res_q    <= '0;
			bvalid_q <= '0;
			wr_q     <= '0;
			cmd_q    <= CMD_TICK;
			idx_q    <= '0;
			a_q      <= '0;
			val_q    <= '0;
			en_q     <= 1'b0;
			tok_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (tm_we) begin
				wr_q[idx_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= item.command;
						idx_q   <= type_x[TW-1:0];
						tok_q   <= (type_x < TXW'(NUM_TYPES));
						a_q     <= OW'(item.address);
						val_q   <= item.byte_value;
						en_q    <= item.base_enable;
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (u_over) begin
						a_q <= u_res;
					end else begin
						case (cmd_q)
							CMD_TICK, CMD_RESTART: begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
							CMD_START, CMD_HALT, CMD_WRITE_BASE, CMD_READ: begin
								if (tok_q) begin
									state_q <= S_TREAD;
								end else begin
									res_q   <= '0;
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							default: begin
								res_q   <= '0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_TREAD: begin
					state_q <= S_TEVAL;
				end
				S_SCAN: begin
					if (bvalid_q[idx_q]) begin
						state_q <= S_TEVAL;
					end else if (last_type) begin
						res_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + TW'(1);
					end
				end
				S_TEVAL: begin
					case (cmd_q)
						CMD_TICK: begin
							if ((rec.cnt != halt_q) && (cnt_dec == '0)) begin
								a_q     <= u_res;
								state_q <= S_CHK;
							end else if (last_type) begin
								res_q   <= '0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q   <= idx_q + TW'(1);
								state_q <= S_SCAN;
							end
						end
						CMD_RESTART: begin
							a_q     <= OW'(rec.base);
							state_q <= S_CHK;
						end
						CMD_START: begin
							state_q <= S_CHK;
						end
						CMD_READ: begin
							state_q <= S_RDOUT;
						end
						CMD_WRITE_BASE: begin
							bvalid_q[idx_q] <= en_q;
							res_q           <= '0;
							done_q          <= 1'b1;
							state_q         <= S_IDLE;
						end
						default: begin
							res_q   <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CHK: begin
					// base is taken as is, no second loop-code check
					a_q     <= OW'(chk_a);
					state_q <= S_CNT;
				end
				S_CNT: begin
					if (((cmd_q == CMD_TICK) || (cmd_q == CMD_RESTART)) && !last_type) begin
						idx_q   <= idx_q + TW'(1);
						state_q <= S_SCAN;
					end else begin
						res_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RDOUT: begin
					res_q.frame_character <= ft_rdata_q;
					res_q.frame_position  <= pos_x[POS_W-1:0];
					res_q.hold_count      <= rec.cnt;
					done_q                <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_ft_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ft_we |-> (a_q < OW'(TABLE_BYTES)))
		else $error("frame table write address not folded");

	a_nonzero_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result != '0)) |-> (cmd_q == CMD_READ))
		else $error("nonzero result for a non-read command");

	a_eval_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TEVAL) |-> $past(tm_re))
		else $error("record evaluated without a fetch");

endmodule
`default_nettype wire
